[rtl/core/sorted_timer_queue_top_assert.svh]
// assertion macros for the sorted timer queue
`ifndef SORTED_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_TIMER_QUEUE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define STQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define STQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define STQ_ASSERT(label, clk, rst_n, prop, msg)
`define STQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/core/stq_pkg.sv]
// shared types and codes for the sorted timer queue
`timescale 1ns / 1ps
package stq_pkg;
  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_SET_IVL = 3'd1,
    REQ_RESTART = 3'd2,
    REQ_EXPIRE  = 3'd3,
    REQ_DELETE  = 3'd4,
    REQ_TICK    = 3'd5
  } req_e;
  localparam int unsigned ReqW = 3;
  localparam int unsigned MaxReports = 8;
  localparam int unsigned NumTimers = 8;
endpackage

[rtl/core/sorted_timer_queue_top.sv]
// sorted timer queue with a single shared compare unit under a sequencer
//
// channel  dir  fields
// s_axis   in   tdata: req_type, slot_id, interval_ticks, periodic_mode
// m_axis   out  tdata: expired_slot, rearmed; tlast: last_event
//
// a command is taken in idle, then runs a remove walk, an apply step and an insert walk;
// create of a free slot skips the remove walk, delete skips the insert walk, expire only sets a flag
// a tick checks one queue entry per cycle while the walk is not stalled; each periodic rearm adds the same walks
// a due report waits in a holding register, the walk stalls while one waits and m_axis is busy
// reset clears time, queue count and slot flags; s_axis_tready is low while
// a command is in work or a report waits on m_axis
`timescale 1ns / 1ps
`include "sorted_timer_queue_top_assert.svh"
module sorted_timer_queue_top import stq_pkg::*; #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned INTERVAL_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[2:0], slot_id[5:3], interval_ticks[21:6], periodic_mode[22]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // expired_slot[2:0], rearmed[3]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);
  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int unsigned CntW = $clog2(NumTimers + 1);
  localparam int unsigned RepW = $clog2(MaxReports + 1);
  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_REM, ST_REM_SHIFT, ST_APPLY, ST_INS_FIND, ST_INS_SHIFT,
    ST_TICK_CHK, ST_OUT
  } state_e;

  state_e                 state_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [IdxW-1:0]        order_q [NumTimers];
  logic [IdxW-1:0]        snap_q [NumTimers];
  logic [CntW-1:0]        count_q, snap_n_q;
  logic [NumTimers-1:0]   valid_q, per_q, exp_q;
  logic [TIME_BITS-1:0]   start_q [NumTimers];
  logic [INTERVAL_BITS-1:0] ivl_q [NumTimers];
  logic [ReqW-1:0]        req_q;
  logic [IdxW-1:0]        slot_q;
  logic [INTERVAL_BITS-1:0] ivl_in_q;
  logic                   per_in_q;
  logic [CntW-1:0]        pos_q;
  logic [CntW-1:0]        ins_q;
  logic [CntW-1:0]        walk_q;
  logic [RepW-1:0]        nrep_q;
  logic                   in_tick_q;
  logic [2:0]             out_slot_q;
  logic                   out_re_q, out_last_q, out_v_q;
  logic [2:0]             pend_slot_q;
  logic                   pend_re_q, pend_v_q;

  logic [2:0]  in_req, in_slot;
  logic [15:0] in_ivl;
  logic [INTERVAL_BITS-1:0] ivl_sat;
  assign in_req  = s_axis_tdata[2:0];
  assign in_slot = s_axis_tdata[5:3];
  assign in_ivl  = s_axis_tdata[21:6];
  always_comb begin
    if (INTERVAL_BITS >= 16) ivl_sat = INTERVAL_BITS'(in_ivl);
    else if ((in_ivl >> (INTERVAL_BITS % 16)) != 16'd0) ivl_sat = '1;
    else ivl_sat = INTERVAL_BITS'(in_ivl);
  end

  // shared compare unit: deadline(slot_q) <= deadline(order at pos_q)
  logic [IdxW-1:0] cmp_b;
  logic [TIME_BITS:0] dl_a, dl_b;
  logic cmp_le;
  assign cmp_b = order_q[pos_q[IdxW-1:0]];
  assign dl_a = {1'b0, start_q[slot_q]} + (TIME_BITS+1)'(ivl_q[slot_q]);
  assign dl_b = {1'b0, start_q[cmp_b]} + (TIME_BITS+1)'(ivl_q[cmp_b]);
  assign cmp_le = dl_a <= dl_b;

  // tick due check on the walked entry
  logic [IdxW-1:0] tk;
  logic [TIME_BITS-1:0] elapsed;
  assign tk = snap_q[walk_q[IdxW-1:0]];
  assign elapsed = now_q - start_q[tk];

  assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'd0, out_re_q, out_slot_q};
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      now_q <= '0;
      count_q <= '0;
      valid_q <= '0;
      per_q <= '0;
      exp_q <= '0;
      out_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      in_tick_q <= 1'b0;
    end else begin
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            req_q <= in_req;
            slot_q <= IdxW'(in_slot);
            ivl_in_q <= ivl_sat;
            per_in_q <= s_axis_tdata[22];
            pos_q <= '0;
            in_tick_q <= 1'b0;
            if (in_req == REQ_TICK) begin
              if (now_q != TimeMax) now_q <= now_q + 1'b1;
              snap_q <= order_q;
              snap_n_q <= count_q;
              walk_q <= '0;
              nrep_q <= '0;
              state_q <= ST_TICK_CHK;
            end else if (in_req <= REQ_DELETE && 32'(in_slot) < NumTimers) begin
              if (in_req == REQ_CREATE || valid_q[IdxW'(in_slot)]) begin
                if (in_req == REQ_EXPIRE) exp_q[IdxW'(in_slot)] <= 1'b1;
                else if (in_req == REQ_CREATE && !valid_q[IdxW'(in_slot)])
                  state_q <= ST_APPLY;
                else state_q <= ST_REM;
              end
            end
          end
        end
        ST_REM: begin
          if (pos_q >= count_q) state_q <= ST_APPLY;
          else if (cmp_b == slot_q) state_q <= ST_REM_SHIFT;
          else pos_q <= pos_q + 1'b1;
        end
        ST_REM_SHIFT: begin
          if (pos_q + 1'b1 < count_q) begin
            order_q[pos_q[IdxW-1:0]] <= order_q[IdxW'(pos_q + 1'b1)];
            pos_q <= pos_q + 1'b1;
          end else begin
            count_q <= count_q - 1'b1;
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          pos_q <= '0;
          state_q <= (req_q == REQ_DELETE) ? ST_IDLE : ST_INS_FIND;
          case (req_q)
            REQ_CREATE: begin
              valid_q[slot_q] <= 1'b1;
              per_q[slot_q] <= per_in_q;
              exp_q[slot_q] <= 1'b0;
              start_q[slot_q] <= now_q;
              ivl_q[slot_q] <= ivl_in_q;
            end
            REQ_SET_IVL: ivl_q[slot_q] <= ivl_in_q;
            REQ_RESTART, REQ_TICK: begin
              exp_q[slot_q] <= 1'b0;
              start_q[slot_q] <= now_q;
            end
            default: begin
              valid_q[slot_q] <= 1'b0;
              per_q[slot_q] <= 1'b0;
              exp_q[slot_q] <= 1'b0;
            end
          endcase
        end
        ST_INS_FIND: begin
          if (32'(count_q) >= NumTimers) begin
            state_q <= in_tick_q ? ST_TICK_CHK : ST_IDLE;
          end else if (pos_q >= count_q || cmp_le) begin
            ins_q <= pos_q;
            state_q <= ST_INS_SHIFT;
            pos_q <= count_q;
          end else pos_q <= pos_q + 1'b1;
        end
        ST_INS_SHIFT: begin
          // shift entries up from the tail until the insert position
          if (pos_q == ins_q) begin
            order_q[pos_q[IdxW-1:0]] <= slot_q;
            count_q <= count_q + 1'b1;
            state_q <= in_tick_q ? ST_TICK_CHK : ST_IDLE;
          end else begin
            order_q[pos_q[IdxW-1:0]] <= order_q[IdxW'(pos_q - 1'b1)];
            pos_q <= pos_q - 1'b1;
          end
        end
        ST_TICK_CHK: begin
          if (walk_q >= snap_n_q || 32'(nrep_q) >= MaxReports) begin
            if (!pend_v_q) begin
              state_q <= ST_IDLE;
            end else if (!out_v_q) begin
              out_v_q <= 1'b1;
              out_slot_q <= pend_slot_q;
              out_re_q <= pend_re_q;
              out_last_q <= 1'b1;
              pend_v_q <= 1'b0;
              state_q <= ST_OUT;
            end
          end else if (!valid_q[tk] || exp_q[tk]) begin
            walk_q <= walk_q + 1'b1;
          end else if (elapsed < TIME_BITS'(ivl_q[tk])) begin
            walk_q <= snap_n_q;
          end else if (!(pend_v_q && out_v_q)) begin
            // held report goes out now that another follows
            if (pend_v_q) begin
              out_v_q <= 1'b1;
              out_slot_q <= pend_slot_q;
              out_re_q <= pend_re_q;
              out_last_q <= 1'b0;
            end
            pend_v_q <= 1'b1;
            pend_slot_q <= 3'(tk);
            pend_re_q <= per_q[tk];
            exp_q[tk] <= 1'b1;
            nrep_q <= nrep_q + 1'b1;
            walk_q <= walk_q + 1'b1;
            if (per_q[tk]) begin
              slot_q <= tk;
              req_q <= REQ_TICK;
              in_tick_q <= 1'b1;
              pos_q <= '0;
              state_q <= ST_REM;
            end
          end
        end
        ST_OUT: begin
          if (!out_v_q) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `STQ_ASSERT(a_cnt_range, clk_i, rst_ni, 32'(count_q) <= NumTimers,
              "queue count above capacity")
  `STQ_ASSERT(a_no_accept_busy, clk_i, rst_ni,
              !(s_axis_tready && state_q != ST_IDLE), "ready while busy")
  `STQ_ASSERT_NEXT(a_time_mono, clk_i, rst_ni, 1'b1, now_q >= $past(now_q),
                   "time counter went back")
endmodule
